@@ design/prtlp_pkg.sv @@
// Shared types and constants for the radar text line parser.
package prtlp_pkg;

    // Longest line held is LINE_CAPACITY-1 characters
    localparam int LINE_CAPACITY = 64;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int NUM_W         = 17;
    localparam int PROD_W        = NUM_W + 4;

    localparam logic [LEN_W-1:0] LINE_LAST  = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [LEN_W-1:0] SKIP_COUNT = LEN_W'(8);
    localparam logic [LEN_W-1:0] OFF_LEN    = LEN_W'(3);
    localparam logic [NUM_W-1:0] NUM_SAT    = NUM_W'(65536);

    localparam logic [15:0] MAX_DIST_RESET = 16'd1000;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_O   = 8'h4F;
    localparam logic [7:0] CHAR_F   = 8'h46;
    localparam logic [7:0] CHAR_D   = 8'h64;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;

    // Digit scan phases
    localparam logic [1:0] SCAN_SEEK = 2'd0;
    localparam logic [1:0] SCAN_RUN  = 2'd1;
    localparam logic [1:0] SCAN_DONE = 2'd2;

    // Result of one byte
    typedef struct packed {
        logic [15:0] distance_cm;
        logic        presence;
        logic        line_done;
        logic        updated;
        logic        overflow;
    } result_t;

    // Expected character at each position of "OFF"
    function automatic logic [7:0] off_char(input logic [1:0] pos);
        logic [7:0] ch;
        case (pos)
            2'd0:    ch = CHAR_O;
            2'd1:    ch = CHAR_F;
            2'd2:    ch = CHAR_F;
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

endpackage

@@ design/prtlp_line_core.sv @@
// Per-byte line parsing state and distance/presence registers.
module prtlp_line_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            byte_in,
    input  logic [15:0]           max_distance,
    output prtlp_pkg::result_t    result
);

    logic [prtlp_pkg::LEN_W-1:0]  line_length_reg, line_length_next;
    logic [1:0]                   off_match_reg, off_match_next;
    logic                         starts_d_reg, starts_d_next;
    logic                         term_reg, term_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [prtlp_pkg::NUM_W-1:0]  number_reg, number_next;
    logic [15:0]                  distance_reg, distance_next;
    logic                         presence_reg, presence_next;

    logic                          is_digit;
    logic [3:0]                    digit_val;
    logic [prtlp_pkg::PROD_W-1:0]  num_prod;
    logic                          done, upd, ovf;

    assign is_digit  = byte_in inside {[prtlp_pkg::CHAR_0:prtlp_pkg::CHAR_9]};
    assign digit_val = 4'(byte_in - prtlp_pkg::CHAR_0);
    assign num_prod  = prtlp_pkg::PROD_W'(number_reg) * prtlp_pkg::PROD_W'(10)
                     + prtlp_pkg::PROD_W'(digit_val);

    // Next state for one received byte
    always_comb begin
        line_length_next = line_length_reg;
        off_match_next   = off_match_reg;
        starts_d_next    = starts_d_reg;
        term_next        = term_reg;
        phase_next       = phase_reg;
        number_next      = number_reg;
        distance_next    = distance_reg;
        presence_next    = presence_reg;
        done             = 1'b0;
        upd              = 1'b0;
        ovf              = 1'b0;

        if (byte_in == prtlp_pkg::CHAR_CR) begin
            // carriage return ignored
        end else if (byte_in == prtlp_pkg::CHAR_LF) begin
            if (line_length_reg != '0) begin
                done = 1'b1;
                if (off_match_reg == 2'd3) begin
                    distance_next = '0;
                    presence_next = 1'b0;
                    upd           = 1'b1;
                end else if (starts_d_reg && number_reg != '0 &&
                             number_reg <= prtlp_pkg::NUM_W'(max_distance)) begin
                    distance_next = number_reg[15:0];
                    presence_next = 1'b1;
                    upd           = 1'b1;
                end
                line_length_next = '0;
                off_match_next   = '0;
                starts_d_next    = 1'b0;
                term_next        = 1'b0;
                phase_next       = prtlp_pkg::SCAN_SEEK;
                number_next      = '0;
            end
        end else if (line_length_reg < prtlp_pkg::LINE_LAST) begin
            line_length_next = line_length_reg + 1'b1;
            if (!term_reg) begin
                if (byte_in == prtlp_pkg::CHAR_NUL) begin
                    // NUL ends the parsed content
                    term_next = 1'b1;
                    if (phase_reg == prtlp_pkg::SCAN_RUN)
                        phase_next = prtlp_pkg::SCAN_DONE;
                end else begin
                    // "OFF" prefix match
                    if (line_length_reg < prtlp_pkg::OFF_LEN &&
                        prtlp_pkg::LEN_W'(off_match_reg) == line_length_reg &&
                        byte_in == prtlp_pkg::off_char(line_length_reg[1:0]))
                        off_match_next = off_match_reg + 2'd1;
                    if (line_length_reg == '0 && byte_in == prtlp_pkg::CHAR_D)
                        starts_d_next = 1'b1;
                    // digit run after the skipped header
                    if (starts_d_reg && line_length_reg >= prtlp_pkg::SKIP_COUNT) begin
                        if (phase_reg == prtlp_pkg::SCAN_SEEK && is_digit)
                            phase_next = prtlp_pkg::SCAN_RUN;
                        else if (phase_reg == prtlp_pkg::SCAN_RUN && !is_digit)
                            phase_next = prtlp_pkg::SCAN_DONE;
                        if (phase_next == prtlp_pkg::SCAN_RUN && is_digit) begin
                            if (num_prod > prtlp_pkg::PROD_W'(prtlp_pkg::NUM_SAT))
                                number_next = prtlp_pkg::NUM_SAT;
                            else
                                number_next = num_prod[prtlp_pkg::NUM_W-1:0];
                        end
                    end
                end
            end
        end else begin
            // line too long: drop byte and restart
            ovf              = 1'b1;
            line_length_next = '0;
            off_match_next   = '0;
            starts_d_next    = 1'b0;
            term_next        = 1'b0;
            phase_next       = prtlp_pkg::SCAN_SEEK;
            number_next      = '0;
        end
    end

    assign result.distance_cm = distance_next;
    assign result.presence    = presence_next;
    assign result.line_done   = done;
    assign result.updated     = upd;
    assign result.overflow    = ovf;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= '0;
            off_match_reg   <= '0;
            starts_d_reg    <= 1'b0;
            term_reg        <= 1'b0;
            phase_reg       <= prtlp_pkg::SCAN_SEEK;
            number_reg      <= '0;
            distance_reg    <= '0;
            presence_reg    <= 1'b0;
        end else if (step) begin
            line_length_reg <= line_length_next;
            off_match_reg   <= off_match_next;
            starts_d_reg    <= starts_d_next;
            term_reg        <= term_next;
            phase_reg       <= phase_next;
            number_reg      <= number_next;
            distance_reg    <= distance_next;
            presence_reg    <= presence_next;
        end
    end

    // Checks
    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_length_reg <= prtlp_pkg::LINE_LAST)
        else $error("line length beyond capacity");
    a_num_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        number_reg <= prtlp_pkg::NUM_SAT)
        else $error("digit value above saturation");
    a_num_only_d: assert property (@(posedge aclk) disable iff (!aresetn)
        number_reg != '0 |-> starts_d_reg && phase_reg != prtlp_pkg::SCAN_SEEK)
        else $error("digit value outside a d line run");

endmodule

@@ design/presence_radar_text_line_parser_top.sv @@
// Top level of the presence radar text line parser.
//
// Usage: sensor text bytes arrive on the s_ channel (s_valid/s_ready,
// s_rx_byte), one byte per request. Every accepted byte yields exactly one
// result request on the m_ channel: current distance and presence, plus
// line_done, updated and overflow flags for that byte.
// The max_distance register is written through cfg_valid/cfg_ready/
// cfg_max_distance; cfg_ready is always high. Write it only while idle.
// An accepted byte waits in the input register, is parsed into the result
// register and is offered from there.
// Throughput: one byte per cycle while the receiver keeps taking results,
// set by the combinational parse stage between the input and result registers.
// Reset (aresetn low, synchronous) clears line state, distance, presence,
// both stages, and loads max_distance with 1000.
// When the receiver stalls, the result register holds and the input
// register can still take one more byte; s_ready drops after that.
module presence_radar_text_line_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_distance_cm,
    output logic        m_presence,
    output logic        m_line_done,
    output logic        m_updated,
    output logic        m_overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_max_distance
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    prtlp_pkg::result_t out_reg;
    prtlp_pkg::result_t core_result;
    logic [15:0]        max_distance_reg;
    logic               advance;

    // Parse stage advances when the result slot is free or being taken
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            max_distance_reg <= prtlp_pkg::MAX_DIST_RESET;
        else if (cfg_valid)
            max_distance_reg <= cfg_max_distance;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else if (s_ready)
            in_valid_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            in_byte_reg <= s_rx_byte;
    end

    prtlp_line_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .byte_in      (in_byte_reg),
        .max_distance (max_distance_reg),
        .result       (core_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (advance)
            out_reg <= core_result;
    end

    assign m_valid       = out_valid_reg;
    assign m_distance_cm = out_reg.distance_cm;
    assign m_presence    = out_reg.presence;
    assign m_line_done   = out_reg.line_done;
    assign m_updated     = out_reg.updated;
    assign m_overflow    = out_reg.overflow;

    // Checks
    a_upd_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_updated |-> m_line_done)
        else $error("update without a completed line");
    a_done_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_line_done && m_overflow))
        else $error("line done and overflow together");
    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_presence |-> m_distance_cm == 16'd0)
        else $error("distance set while nobody present");
    a_present_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_presence |-> m_distance_cm != 16'd0)
        else $error("zero distance while present");

endmodule
